@@ hw/rtl/frx_pkg.sv @@
// Package for the framed block demultiplexing receiver: shared types, constants,
// and the CRC-8 and target match functions.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package frx_pkg;

   localparam int MAX_TARGETS = 8;
   localparam int TARGET_BITS = 7;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 56;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SYNC_FIRST = 8'hC3;
   localparam logic [7:0] SYNC_SECOND = 8'hA9;
   localparam logic [7:0] TARGET_MASK = 8'h7F;
   localparam logic [7:0] RESET_POLY = 8'h07;
   localparam logic [7:0] RESET_MAX_LEN = 8'd32;
   localparam logic [7:0] MIN_MESSAGE_LEN = 8'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_COUNT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_NUMBERS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRC_POLYNOMIAL = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_MESSAGE_LENGTH = 2'd3;

   localparam logic KIND_MESSAGE = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   localparam logic [1:0] SPLIT_CLEAN = 2'd0;
   localparam logic [1:0] SPLIT_BAD_LENGTH = 2'd1;
   localparam logic [1:0] SPLIT_OVERRUN = 2'd2;

   typedef struct packed {
      logic [3:0] target_count;
      logic [CSR_DATA_WIDTH-1:0] target_numbers;
      logic [7:0] crc_polynomial;
      logic [7:0] max_message_length;
   } cfg_type;

   typedef struct packed {
      logic kind;
      logic [7:0] data_byte;
      logic [7:0] target_hits;
      logic message_last;
      logic [7:0] frame_version;
      logic crc_ok;
      logic [1:0] split_status;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] match_targets(input logic [TARGET_BITS-1:0] tgt,
                                                input logic [3:0] count,
                                                input logic [CSR_DATA_WIDTH-1:0] numbers);
      logic [7:0] hits;
      hits = '0;
      for (int k = 0; k < MAX_TARGETS; k++) begin
         if ((4'(k) < count) && (numbers[TARGET_BITS*k +: TARGET_BITS] == tgt)) begin
            hits[k] = 1'b1;
         end
      end
      return hits;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/frx_parser.sv @@
// Frame and message parser: sync hunt, block bookkeeping, CRC and target routing.
// It takes one registered byte and produces up to two results. It depends on frx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frx_parser (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  wire logic [7:0] rx_byte,
   input  wire frx_pkg::cfg_type cfg,
   output frx_pkg::push_type push
);

   typedef enum logic [2:0] {
      PH_HUNT1, PH_HUNT2, PH_VERSION, PH_LENGTH, PH_DATA, PH_CRC
   } phase_type;

   typedef enum logic [1:0] {
      MP_LENGTH, MP_TARGET, MP_PAYLOAD, MP_ABANDONED
   } msg_phase_type;

   phase_type phase_ff, phase_in;
   msg_phase_type msg_phase_ff, msg_phase_in;
   logic [7:0] block_length_ff, block_length_in;
   logic [7:0] block_count_ff, block_count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] version_ff, version_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] held_length_ff, held_length_in;
   logic [7:0] hits_ff, hits_in;
   logic [1:0] split_ff, split_in;

   logic block_end;
   logic last;
   logic [7:0] count_inc;
   logic [7:0] remaining_dec;
   logic [7:0] new_hits;
   frx_pkg::result_type msg_result;

   assign count_inc = block_count_ff + 8'd1;
   assign block_end = (count_inc == block_length_ff);
   assign remaining_dec = remaining_ff - 8'd1;
   assign new_hits = frx_pkg::match_targets(frx_pkg::TARGET_BITS'(rx_byte & frx_pkg::TARGET_MASK),
                                            cfg.target_count, cfg.target_numbers);

   always_comb begin
      phase_in = phase_ff;
      msg_phase_in = msg_phase_ff;
      block_length_in = block_length_ff;
      block_count_in = block_count_ff;
      crc_in = crc_ff;
      version_in = version_ff;
      remaining_in = remaining_ff;
      held_length_in = held_length_ff;
      hits_in = hits_ff;
      split_in = split_ff;
      last = 1'b0;
      msg_result = '0;
      msg_result.kind = frx_pkg::KIND_MESSAGE;
      push = '0;
      if (step) begin
         case (phase_ff)
            PH_HUNT1: begin
               if (rx_byte == frx_pkg::SYNC_FIRST) begin
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               phase_in = (rx_byte == frx_pkg::SYNC_SECOND) ? PH_VERSION : PH_HUNT1;
            end
            PH_VERSION: begin
               version_in = rx_byte;
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               block_length_in = rx_byte;
               block_count_in = '0;
               crc_in = '0;
               msg_phase_in = MP_LENGTH;
               remaining_in = '0;
               held_length_in = '0;
               hits_in = '0;
               split_in = frx_pkg::SPLIT_CLEAN;
               phase_in = (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
               crc_in = frx_pkg::crc_update(crc_ff, rx_byte, cfg.crc_polynomial);
               block_count_in = count_inc;
               case (msg_phase_ff)
                  MP_LENGTH: begin
                     if ((rx_byte < frx_pkg::MIN_MESSAGE_LEN) ||
                         (rx_byte > cfg.max_message_length)) begin
                        split_in = frx_pkg::SPLIT_BAD_LENGTH;
                        msg_phase_in = MP_ABANDONED;
                     end else begin
                        held_length_in = rx_byte;
                        remaining_in = rx_byte - frx_pkg::MIN_MESSAGE_LEN;
                        msg_phase_in = MP_TARGET;
                        if (block_end) begin
                           split_in = frx_pkg::SPLIT_OVERRUN;
                        end
                     end
                  end
                  MP_TARGET: begin
                     last = (remaining_ff == 8'd0) || block_end;
                     hits_in = new_hits;
                     if (new_hits != 8'd0) begin
                        push.count = 2'd2;
                        push.first = msg_result;
                        push.first.data_byte = held_length_ff;
                        push.first.target_hits = new_hits;
                        push.second = msg_result;
                        push.second.data_byte = rx_byte;
                        push.second.target_hits = new_hits;
                        push.second.message_last = last;
                     end
                     if (remaining_ff == 8'd0) begin
                        msg_phase_in = MP_LENGTH;
                     end else begin
                        msg_phase_in = MP_PAYLOAD;
                        if (block_end) begin
                           split_in = frx_pkg::SPLIT_OVERRUN;
                        end
                     end
                  end
                  MP_PAYLOAD: begin
                     remaining_in = remaining_dec;
                     last = (remaining_dec == 8'd0) || block_end;
                     if (hits_ff != 8'd0) begin
                        push.count = 2'd1;
                        push.first = msg_result;
                        push.first.data_byte = rx_byte;
                        push.first.target_hits = hits_ff;
                        push.first.message_last = last;
                     end
                     if (remaining_dec == 8'd0) begin
                        msg_phase_in = MP_LENGTH;
                     end else if (block_end) begin
                        split_in = frx_pkg::SPLIT_OVERRUN;
                     end
                  end
                  default: begin
                  end
               endcase
               if (block_end) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               push.count = 2'd1;
               push.first.kind = frx_pkg::KIND_FRAME_END;
               push.first.frame_version = version_ff;
               push.first.crc_ok = (rx_byte == crc_ff);
               push.first.split_status = split_ff;
               phase_in = PH_HUNT1;
            end
            default: begin
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         msg_phase_ff <= MP_LENGTH;
         block_length_ff <= '0;
         block_count_ff <= '0;
         crc_ff <= '0;
         version_ff <= '0;
         remaining_ff <= '0;
         held_length_ff <= '0;
         hits_ff <= '0;
         split_ff <= frx_pkg::SPLIT_CLEAN;
      end else begin
         phase_ff <= phase_in;
         msg_phase_ff <= msg_phase_in;
         block_length_ff <= block_length_in;
         block_count_ff <= block_count_in;
         crc_ff <= crc_in;
         version_ff <= version_in;
         remaining_ff <= remaining_in;
         held_length_ff <= held_length_in;
         hits_ff <= hits_in;
         split_ff <= split_in;
      end
   end

   a_push_needs_step: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> step)
      else $error("results produced without a byte being parsed");

   a_frame_end_alone: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.first.kind == frx_pkg::KIND_MESSAGE &&
                                push.second.kind == frx_pkg::KIND_MESSAGE))
      else $error("frame-end report paired with another result");

   a_block_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (block_count_ff < block_length_ff))
      else $error("block count passed the block length");

endmodule

`default_nettype wire

@@ hw/rtl/frx_out_queue.sv @@
// Result queue of the receiver: takes up to two results a cycle, hands out one while out_stall is low.
// It depends on frx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frx_out_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire frx_pkg::push_type push,
   output logic room,
   output logic out_valid,
   input  wire logic out_stall,
   output frx_pkg::result_type out_result
);

   frx_pkg::result_type mem_ff [frx_pkg::QUEUE_DEPTH];
   logic [frx_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [frx_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [frx_pkg::QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [frx_pkg::QUEUE_PTR_WIDTH-1:0] wr_next;
   logic pop;

   assign out_valid = (count_ff != '0);
   assign out_result = mem_ff[rd_ptr_ff];
   assign pop = out_valid && !out_stall;
   assign room = (count_ff <= frx_pkg::QUEUE_COUNT_WIDTH'(frx_pkg::QUEUE_DEPTH - 2));
   assign wr_next = wr_ptr_ff + 1'b1;

   assign wr_ptr_in = wr_ptr_ff + frx_pkg::QUEUE_PTR_WIDTH'(push.count);
   assign rd_ptr_in = rd_ptr_ff + frx_pkg::QUEUE_PTR_WIDTH'(pop);
   assign count_in = count_ff + frx_pkg::QUEUE_COUNT_WIDTH'(push.count)
                     - frx_pkg::QUEUE_COUNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= frx_pkg::QUEUE_COUNT_WIDTH'(frx_pkg::QUEUE_DEPTH))
      else $error("result queue holds more than its depth");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("results pushed into a queue without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0 && pop) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count wrong after a lone pop");

endmodule

`default_nettype wire

@@ hw/rtl/framed_block_demux_receiver.sv @@
// Top level of the framed block demultiplexing receiver: input register,
// configuration registers, parser and result queue. It depends on frx_pkg,
// frx_parser and frx_out_queue.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_rx_byte
//   rsp_      out        rsp_valid / rsp_stall  rsp_kind .. rsp_split_status
//   csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// An item is registered on acceptance and parsed once the queue has room; its results
// are written into the result queue and offered from its head.
// A byte can be taken every cycle while the queue has room; a matched target byte
// yields two results, and the single result port then hands them out one at a time.
// Reset clears the parser state and the queue, and sets the configuration registers to their defaults.
// req_stall is raised while the input register holds an item and the queue lacks room.
`timescale 1ns / 1ps
`default_nettype none

module framed_block_demux_receiver (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_target_hits,
   output logic rsp_message_last,
   output logic [7:0] rsp_frame_version,
   output logic rsp_crc_ok,
   output logic [1:0] rsp_split_status,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [frx_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [frx_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   frx_pkg::cfg_type cfg_ff, cfg_in;
   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic room;
   logic step;
   logic req_take;
   frx_pkg::push_type push;
   frx_pkg::result_type head;

   assign csr_ready = 1'b1;
   assign step = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !step);
   assign in_byte_in = req_take ? req_rx_byte : in_byte_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            frx_pkg::CSR_TARGET_COUNT: cfg_in.target_count = csr_data[3:0];
            frx_pkg::CSR_TARGET_NUMBERS: cfg_in.target_numbers = csr_data;
            frx_pkg::CSR_CRC_POLYNOMIAL: cfg_in.crc_polynomial = csr_data[7:0];
            frx_pkg::CSR_MAX_MESSAGE_LENGTH: cfg_in.max_message_length = csr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_count <= '0;
         cfg_ff.target_numbers <= '0;
         cfg_ff.crc_polynomial <= frx_pkg::RESET_POLY;
         cfg_ff.max_message_length <= frx_pkg::RESET_MAX_LEN;
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   frx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .push    (push)
   );

   frx_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (head)
   );

   assign rsp_kind = head.kind;
   assign rsp_data_byte = head.data_byte;
   assign rsp_target_hits = head.target_hits;
   assign rsp_message_last = head.message_last;
   assign rsp_frame_version = head.frame_version;
   assign rsp_crc_ok = head.crc_ok;
   assign rsp_split_status = head.split_status;

endmodule

`default_nettype wire
